[design/text_console_writer_defines.svh]
// ----------------------------------------------------------------------------
// Text console writer: assertion macros
// Shorthand for the clocked, reset-qualified checks of the console writer.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("text console writer check failed");

// Consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("text console writer check failed");

`endif

[design/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// Text console writer package
// Item mode codes, character codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] ATTR_RESET = 8'h0F;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // an item is taken this cycle
    logic put;       // execute a put item
    logic clear;     // start a clear of the whole screen
    logic capture;   // capture read data
    logic sweep;     // write one blank cell of a sweep
    logic load_out;  // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic put_scrolls;
    logic read_ok;
    logic sweep_last;
    logic out_free;
  } status_t;

endpackage

[design/text_console_writer.sv]
// ----------------------------------------------------------------------------
// Text console writer
// Teletype-style writer into a ROWS by COLS store of attribute/character cells,
// with newline, carriage return, wrap, scroll, clear and cell read.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Carries
//  in_       in_valid / in_ready    mode, character, read row and column
//  out_      out_valid / out_ready  cell, cursor row and column, scrolled flag
//  cfg_      cfg_valid / cfg_ready  text attribute byte
//
//  A put goes straight to its result; a put that scrolls first blanks the
//  bottom row, one cell per cycle through the single RAM write port.
//  A read inside the screen waits for the registered RAM read; a read outside
//  it or an unused mode does not; a clear blanks all ROWS * COLS cells.
//  After reset a blanking pass over all ROWS * COLS cells runs before the first
//  item is taken; configuration writes are taken throughout.
//  A stalled output holds the finished item and the next one waits for it.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_char_code,
  input  logic [4:0]  in_read_row,
  input  logic [6:0]  in_read_col,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_cell_value,
  output logic [4:0]  out_cursor_row_out,
  output logic [6:0]  out_cursor_col_out,
  output logic        out_scrolled,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  import tcw_pkg::*;

  cmd_t    cmd;
  status_t st;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_mode  (in_mode),
    .st       (st),
    .cmd      (cmd)
  );

  tcw_dp #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .in_char_code       (in_char_code),
    .in_read_row        (in_read_row),
    .in_read_col        (in_read_col),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_cell_value     (out_cell_value),
    .out_cursor_row_out (out_cursor_row_out),
    .out_cursor_col_out (out_cursor_col_out),
    .out_scrolled       (out_scrolled)
  );

endmodule

[design/tcw_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/tcw_ctrl.sv]
// ----------------------------------------------------------------------------
// Text console writer controller
// Sequences item execution, blanking sweeps, reads and result hand-off.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_mode,
  input  tcw_pkg::status_t st,
  output tcw_pkg::cmd_t   cmd
);

  import tcw_pkg::*;

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_SWEEP  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_INIT: begin
        // Blanking pass over the whole store after reset.
        cmd.sweep = 1'b1;
        if (st.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (in_mode)
            MODE_PUT: begin
              cmd.put   = 1'b1;
              state_nxt = st.put_scrolls ? S_SWEEP : S_DONE;
            end
            MODE_CLEAR: begin
              cmd.clear = 1'b1;
              state_nxt = S_SWEEP;
            end
            MODE_READ: begin
              state_nxt = st.read_ok ? S_RDWAIT : S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_RDWAIT: begin
        cmd.capture = 1'b1;
        state_nxt   = S_DONE;
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (st.sweep_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[design/tcw_dp.sv]
// ----------------------------------------------------------------------------
// Text console writer datapath
// Cursor, scroll offset, blanking sweep counter, cell store and result
// registers.
// ----------------------------------------------------------------------------
module tcw_dp #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tcw_pkg::cmd_t    cmd,
  output tcw_pkg::status_t st,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [7:0]       cfg_data,
  input  logic [7:0]       in_char_code,
  input  logic [4:0]       in_read_row,
  input  logic [6:0]       in_read_col,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [15:0]      out_cell_value,
  output logic [4:0]       out_cursor_row_out,
  output logic [6:0]       out_cursor_col_out,
  output logic             out_scrolled
);

  import tcw_pkg::*;

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int AW = RW + CW;
  localparam logic [RW:0]   ROWS_M = (RW + 1)'(ROWS);
  localparam logic [CW:0]   COLS_M = (CW + 1)'(COLS);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);

  // Rows are kept as a ring: logical row r lives in physical row
  // (r + top_r) mod ROWS, so a scroll only moves top_r and blanks one row.
  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] r,
                                              input logic [RW-1:0] t);
    logic [RW:0] sum;
    sum = {1'b0, r} + {1'b0, t};
    if (sum >= ROWS_M) begin
      sum = sum - ROWS_M;
    end
    return sum[RW-1:0];
  endfunction

  logic [7:0]    attr_r;
  logic [RW-1:0] cur_row_r;
  logic [CW-1:0] cur_col_r;
  logic [RW-1:0] top_r;
  logic [RW-1:0] sw_row_r;
  logic [CW-1:0] sw_col_r;
  logic          sw_one_r;
  logic [15:0]   sw_blank_r;
  logic [15:0]   res_cell_r;
  logic          res_scr_r;
  logic          out_valid_r;
  logic [15:0]   out_cell_r;
  logic [4:0]    out_row_r;
  logic [6:0]    out_col_r;
  logic          out_scr_r;

  logic          is_nl;
  logic          is_cr;
  logic          printable;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic          col_wrap;
  logic          scroll;
  logic          rd_ok;
  logic [AW-1:0] put_addr;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic          we;
  logic [15:0]   rdata;
  logic          sweep_last;

  assign is_nl     = (in_char_code == CH_NEWLINE);
  assign is_cr     = (in_char_code == CH_RETURN);
  assign printable = !is_nl && !is_cr;
  assign col_inc   = {1'b0, cur_col_r} + (CW + 1)'(1);
  assign row_inc   = {1'b0, cur_row_r} + (RW + 1)'(1);
  assign col_wrap  = (col_inc == COLS_M);
  assign scroll    = (is_nl || (printable && col_wrap)) && (row_inc == ROWS_M);

  assign rd_ok   = (8'(in_read_row) < 8'(ROWS)) && (9'(in_read_col) < 9'(COLS));
  assign put_addr = {phys_row(cur_row_r, top_r), cur_col_r};
  assign rd_addr  = {phys_row(RW'(in_read_row), top_r), CW'(in_read_col)};

  assign sweep_last = (sw_col_r == LAST_COL) && (sw_one_r || (sw_row_r == LAST_ROW));

  assign we    = cmd.sweep || (cmd.put && printable);
  assign waddr = cmd.sweep ? {sw_row_r, sw_col_r} : put_addr;
  assign wdata = cmd.sweep ? sw_blank_r : {attr_r, in_char_code};

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (2 ** AW)
  ) u_cells (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign st.put_scrolls = scroll;
  assign st.read_ok     = rd_ok;
  assign st.sweep_last  = sweep_last;
  assign st.out_free    = !out_valid_r || out_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r      <= ATTR_RESET;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      top_r       <= '0;
      sw_row_r    <= '0;
      sw_col_r    <= '0;
      sw_one_r    <= 1'b0;
      sw_blank_r  <= {ATTR_RESET, CH_SPACE};
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        attr_r <= cfg_data;
      end

      if (cmd.put) begin
        if (is_cr) begin
          cur_col_r <= '0;
        end else if (is_nl) begin
          cur_col_r <= '0;
          if (!scroll) begin
            cur_row_r <= row_inc[RW-1:0];
          end
        end else begin
          cur_col_r <= col_wrap ? '0 : col_inc[CW-1:0];
          if (col_wrap && !scroll) begin
            cur_row_r <= row_inc[RW-1:0];
          end
        end
        // On a scroll the cursor is already on the last row and stays there.
        // The old top row becomes the new bottom row, which is blanked.
        if (scroll) begin
          top_r      <= phys_row(top_r, RW'(1));
          sw_row_r   <= top_r;
          sw_col_r   <= '0;
          sw_one_r   <= 1'b1;
          sw_blank_r <= {attr_r, CH_SPACE};
        end
      end

      if (cmd.clear) begin
        cur_row_r  <= '0;
        cur_col_r  <= '0;
        top_r      <= '0;
        sw_row_r   <= '0;
        sw_col_r   <= '0;
        sw_one_r   <= 1'b0;
        sw_blank_r <= {attr_r, CH_SPACE};
      end

      if (cmd.sweep) begin
        if (sw_col_r == LAST_COL) begin
          sw_col_r <= '0;
          sw_row_r <= sw_row_r + RW'(1);
        end else begin
          sw_col_r <= sw_col_r + CW'(1);
        end
      end

      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_cell_r <= '0;
      res_scr_r  <= cmd.put && scroll;
    end
    if (cmd.capture) begin
      res_cell_r <= rdata;
    end
    if (cmd.load_out) begin
      out_cell_r <= res_cell_r;
      out_row_r  <= 5'(cur_row_r);
      out_col_r  <= 7'(cur_col_r);
      out_scr_r  <= res_scr_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_cell_value     = out_cell_r;
  assign out_cursor_row_out = out_row_r;
  assign out_cursor_col_out = out_col_r;
  assign out_scrolled       = out_scr_r;

endmodule

[design/text_console_writer_checker.sv]
// ----------------------------------------------------------------------------
// Text console writer checker
// Port-level checks on result holding, scroll position and item ordering.
// ----------------------------------------------------------------------------
`include "text_console_writer_defines.svh"

module text_console_writer_checker #(
  parameter int ROWS = 25
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_cell_value,
  input logic [4:0]  out_cursor_row_out,
  input logic [6:0]  out_cursor_col_out,
  input logic        out_scrolled
);

  logic [28:0] out_payload;
  logic        at_last_row_start;

  assign out_payload = {out_cell_value, out_cursor_row_out, out_cursor_col_out, out_scrolled};
  assign at_last_row_start = (out_cursor_row_out == 5'(ROWS - 1)) &&
                             (out_cursor_col_out == 7'd0);

  // A stalled result keeps its payload.
  `TCW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))

  // A scroll always leaves the cursor at the start of the last row.
  `TCW_ASSERT_NOW(a_scroll_pos, out_valid && out_scrolled, at_last_row_start)

  // Items are handled one at a time, so no item is taken on the next cycle.
  `TCW_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)

endmodule

bind text_console_writer text_console_writer_checker #(.ROWS(ROWS)) u_checker (.*);
